[src/h2e_pkg.sv]
package h2e_pkg;

  // Default width of one Hessian entry on the input stream.
  localparam int ENTRY_WIDTH_DEF = 16;

  // Result field widths.
  localparam int EIG_W = 19;
  localparam int VEC_W = 16;

  // Fractional bits of a unit vector component (Q1.15).
  localparam int VEC_FRAC = 15;

  // Result stream payload, packed from the lowest bit up, rounded to bytes.
  localparam int OUT_TDATA_W = ((2 * EIG_W + 4 * VEC_W + 7) / 8) * 8;

  // Width used for range checks that must hold at any entry width.
  localparam int CMP_W = 40;

  localparam logic signed [CMP_W-1:0] EIG_MAX = CMP_W'(262143);
  localparam logic signed [CMP_W-1:0] EIG_MIN = -CMP_W'(262144);
  localparam logic [CMP_W-1:0] VEC_LIM = CMP_W'(32767);

endpackage

[src/h2e_sqrt_cell.sv]
// One step of a digit-by-digit floor square root: decides root bit K.
module h2e_sqrt_cell #(
  parameter int RW = 17,
  parameter int K  = 0,
  parameter int PW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*RW-1:0] in_rem,
  input  logic [RW-1:0]   in_root,
  input  logic [PW-1:0]   in_pay,
  output logic            out_valid,
  output logic [2*RW-1:0] out_rem,
  output logic [RW-1:0]   out_root,
  output logic [PW-1:0]   out_pay
);

  logic            valid_r;
  logic [2*RW-1:0] rem_r, rem_nxt;
  logic [RW-1:0]   root_r, root_nxt;
  logic [PW-1:0]   pay_r;
  logic [2*RW-1:0] trial;

  // The remainder holds N - root^2; adding bit K costs 2*root*2^K + 4^K.
  always_comb begin
    trial = ((2*RW)'(in_root) << (K + 1)) + ((2*RW)'(1) << (2 * K));
    if (trial <= in_rem) begin
      rem_nxt  = in_rem - trial;
      root_nxt = in_root | (RW'(1) << K);
    end else begin
      rem_nxt  = in_rem;
      root_nxt = in_root;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      pay_r  <= in_pay;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_root  = root_r;
  assign out_pay   = pay_r;

endmodule

[src/h2e_div_cell.sv]
// One restoring long-division step for both vector components at once.
module h2e_div_cell #(
  parameter int NW = 18,
  parameter int PW = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [NW-1:0]              in_norm,
  input  logic [NW-1:0]              in_rem_x,
  input  logic [NW-1:0]              in_rem_y,
  input  logic [h2e_pkg::VEC_FRAC-1:0] in_q_x,
  input  logic [h2e_pkg::VEC_FRAC-1:0] in_q_y,
  input  logic [PW-1:0]              in_pay,
  output logic                       out_valid,
  output logic [NW-1:0]              out_norm,
  output logic [NW-1:0]              out_rem_x,
  output logic [NW-1:0]              out_rem_y,
  output logic [h2e_pkg::VEC_FRAC-1:0] out_q_x,
  output logic [h2e_pkg::VEC_FRAC-1:0] out_q_y,
  output logic [PW-1:0]              out_pay
);

  localparam int QW = h2e_pkg::VEC_FRAC;

  logic          valid_r;
  logic [NW-1:0] norm_r;
  logic [NW-1:0] rem_x_r, rem_x_nxt, rem_y_r, rem_y_nxt;
  logic [QW-1:0] q_x_r, q_x_nxt, q_y_r, q_y_nxt;
  logic [PW-1:0] pay_r;
  logic [NW:0]   dbl_x, dbl_y;
  logic          ge_x, ge_y;

  always_comb begin
    dbl_x     = {in_rem_x, 1'b0};
    dbl_y     = {in_rem_y, 1'b0};
    ge_x      = dbl_x >= {1'b0, in_norm};
    ge_y      = dbl_y >= {1'b0, in_norm};
    rem_x_nxt = ge_x ? NW'(dbl_x - {1'b0, in_norm}) : dbl_x[NW-1:0];
    rem_y_nxt = ge_y ? NW'(dbl_y - {1'b0, in_norm}) : dbl_y[NW-1:0];
    q_x_nxt   = {in_q_x[QW-2:0], ge_x};
    q_y_nxt   = {in_q_y[QW-2:0], ge_y};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      norm_r  <= in_norm;
      rem_x_r <= rem_x_nxt;
      rem_y_r <= rem_y_nxt;
      q_x_r   <= q_x_nxt;
      q_y_r   <= q_y_nxt;
      pay_r   <= in_pay;
    end
  end

  assign out_valid = valid_r;
  assign out_norm  = norm_r;
  assign out_rem_x = rem_x_r;
  assign out_rem_y = rem_y_r;
  assign out_q_x   = q_x_r;
  assign out_q_y   = q_y_r;
  assign out_pay   = pay_r;

endmodule

[src/hessian2_eigen_decomposition_top.sv]
// Eigen decomposition of a 2x2 symmetric Hessian, one matrix per transaction.
// Input stream: in_tdata carries dxx, dxy, dyy (ENTRY_WIDTH bits each, signed).
// Result stream: out_tdata carries both doubled eigenvalues, smaller magnitude
// first, and the two matching Q1.15 unit eigenvectors.
// Configuration: cfg_data sets norm_floor; a vector is normalized only when
// its norm exceeds it. Write it only while the pipeline is empty.
// The datapath is a chain of cells: a square-root chain for the discriminant
// (ENTRY_WIDTH+1 cells), one for the vector norm (ENTRY_WIDTH+2 cells) and a
// 15-cell division chain, plus six staging registers.
// Throughput is one transaction per cycle; every cell passes its data on each
// enabled cycle. When the receiver holds out_tready low with a result waiting,
// the whole chain stalls and in_tready drops in the same cycle; nothing is lost.
// Reset clears every valid flag and sets norm_floor to zero; no result is
// presented until a new transaction has passed the full chain.
module hessian2_eigen_decomposition_top #(
  parameter int ENTRY_WIDTH = h2e_pkg::ENTRY_WIDTH_DEF,
  parameter int IN_TDATA_W  = ((3 * ENTRY_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [IN_TDATA_W-1:0]           in_tdata,   // dxx, dxy, dyy
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // eig_small_x2, eig_large_x2, vec_small_x, vec_small_y, vec_large_x, vec_large_y
  output logic [h2e_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [15:0]                     cfg_data
);

  localparam int W   = ENTRY_WIDTH;
  localparam int AW  = W + 1;
  localparam int R1  = W + 1;
  localparam int EW  = W + 3;
  localparam int R2  = W + 2;
  localparam int VW  = W + 3;
  localparam int QW  = h2e_pkg::VEC_FRAC;
  localparam int CW  = h2e_pkg::CMP_W;
  localparam int P1W = 3 * AW;
  localparam int P2W = VW + AW + 2 * EW;
  localparam int P3W = 2 * EW + 5 + 2 * QW;
  localparam int OPAD = h2e_pkg::OUT_TDATA_W - 2 * h2e_pkg::EIG_W - 4 * h2e_pkg::VEC_W;

  logic en;
  logic [15:0] norm_floor_r;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_floor_r <= '0;
    end else if (cfg_valid) begin
      norm_floor_r <= cfg_data;
    end
  end

  // Stage A: differences and sums.
  logic [W-1:0] dxx, dxy, dyy;
  logic va_r;
  logic signed [AW-1:0] a_r, b_r, s_r;

  assign dxx = in_tdata[W-1:0];
  assign dxy = in_tdata[2*W-1:W];
  assign dyy = in_tdata[3*W-1:2*W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= $signed({dxx[W-1], dxx}) - $signed({dyy[W-1], dyy});
      b_r <= $signed({dxy, 1'b0});
      s_r <= $signed({dxx[W-1], dxx}) + $signed({dyy[W-1], dyy});
    end
  end

  // Stage B: a^2 + b^2.
  logic [AW-1:0] ma, mb;
  logic vb_r;
  logic [2*R1-1:0] n1_r;
  logic [P1W-1:0] p1_r;

  assign ma = a_r[AW-1] ? AW'(-a_r) : AW'(a_r);
  assign mb = b_r[AW-1] ? AW'(-b_r) : AW'(b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_r <= (2*R1)'(ma * ma) + (2*R1)'(mb * mb);
      p1_r <= {s_r, b_r, a_r};
    end
  end

  // Discriminant square-root chain.
  logic            c1_v   [R1+1];
  logic [2*R1-1:0] c1_rem [R1+1];
  logic [R1-1:0]   c1_root[R1+1];
  logic [P1W-1:0]  c1_pay [R1+1];

  assign c1_v[0]    = vb_r;
  assign c1_rem[0]  = n1_r;
  assign c1_root[0] = '0;
  assign c1_pay[0]  = p1_r;

  for (genvar i = 0; i < R1; i++) begin : g_sq1
    h2e_sqrt_cell #(.RW(R1), .K(R1 - 1 - i), .PW(P1W)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(c1_v[i]), .in_rem(c1_rem[i]), .in_root(c1_root[i]), .in_pay(c1_pay[i]),
      .out_valid(c1_v[i+1]), .out_rem(c1_rem[i+1]), .out_root(c1_root[i+1]),
      .out_pay(c1_pay[i+1])
    );
  end

  // Stage C: vector for the larger root and both candidate eigenvalues.
  logic signed [AW-1:0] a1, b1, s1;
  logic signed [EW-1:0] disc_s;
  logic vc_r;
  logic signed [VW-1:0] vx_r;
  logic signed [AW-1:0] vy_r;
  logic signed [EW-1:0] e0_r, e1_r;

  assign a1     = c1_pay[R1][AW-1:0];
  assign b1     = c1_pay[R1][2*AW-1:AW];
  assign s1     = c1_pay[R1][3*AW-1:2*AW];
  assign disc_s = $signed({2'b00, c1_root[R1]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= c1_v[R1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx_r <= VW'(EW'(a1) + disc_s);
      vy_r <= b1;
      e0_r <= EW'(s1) - disc_s;
      e1_r <= EW'(s1) + disc_s;
    end
  end

  // Stage D: vx^2 + vy^2.
  logic [R2-1:0] mvx, mvy;
  logic vd_r;
  logic [2*R2-1:0] n2_r;
  logic [P2W-1:0] p2_r;

  assign mvx = vx_r[VW-1] ? R2'(-vx_r) : R2'(vx_r);
  assign mvy = vy_r[AW-1] ? R2'(-EW'(vy_r)) : R2'(vy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n2_r <= (2*R2)'(mvx * mvx) + (2*R2)'(mvy * mvy);
      p2_r <= {e1_r, e0_r, vy_r, vx_r};
    end
  end

  // Norm square-root chain.
  logic            c2_v   [R2+1];
  logic [2*R2-1:0] c2_rem [R2+1];
  logic [R2-1:0]   c2_root[R2+1];
  logic [P2W-1:0]  c2_pay [R2+1];

  assign c2_v[0]    = vd_r;
  assign c2_rem[0]  = n2_r;
  assign c2_root[0] = '0;
  assign c2_pay[0]  = p2_r;

  for (genvar i = 0; i < R2; i++) begin : g_sq2
    h2e_sqrt_cell #(.RW(R2), .K(R2 - 1 - i), .PW(P2W)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(c2_v[i]), .in_rem(c2_rem[i]), .in_root(c2_root[i]), .in_pay(c2_pay[i]),
      .out_valid(c2_v[i+1]), .out_rem(c2_rem[i+1]), .out_root(c2_root[i+1]),
      .out_pay(c2_pay[i+1])
    );
  end

  // Stage E: normalization decision and raw clipping.
  logic signed [VW-1:0] vx2;
  logic signed [AW-1:0] vy2;
  logic signed [EW-1:0] e0_2, e1_2;
  logic [R2-1:0] norm2, mx2, my2;
  logic [CW-1:0] mx_w, my_w;
  logic ve_r;
  logic [R2-1:0] norm_e_r, rx_e_r, ry_e_r;
  logic [P3W-1:0] p3_r;

  assign vx2   = c2_pay[R2][VW-1:0];
  assign vy2   = c2_pay[R2][VW+AW-1:VW];
  assign e0_2  = c2_pay[R2][VW+AW+EW-1:VW+AW];
  assign e1_2  = c2_pay[R2][P2W-1:VW+AW+EW];
  assign norm2 = c2_root[R2];
  assign mx2   = vx2[VW-1] ? R2'(-vx2) : R2'(vx2);
  assign my2   = vy2[AW-1] ? R2'(-EW'(vy2)) : R2'(vy2);
  assign mx_w  = CW'(mx2);
  assign my_w  = CW'(my2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (en) begin
      ve_r <= c2_v[R2];
    end
  end

  // Payload: clip_y, clip_x, big_y, big_x, nz, neg_y, neg_x, e0, e1 from the top down.
  always_ff @(posedge clk) begin
    if (en) begin
      norm_e_r <= norm2;
      rx_e_r   <= mx2;
      ry_e_r   <= my2;
      p3_r <= {
        (my_w > h2e_pkg::VEC_LIM) ? {QW{1'b1}} : my_w[QW-1:0],
        (mx_w > h2e_pkg::VEC_LIM) ? {QW{1'b1}} : mx_w[QW-1:0],
        my2 >= norm2,
        mx2 >= norm2,
        CW'(norm2) > CW'(norm_floor_r),
        vy2[AW-1],
        vx2[VW-1],
        e0_2,
        e1_2
      };
    end
  end

  // Division chain: 32768 * |v| / norm, one quotient bit per cell.
  logic          c3_v   [QW+1];
  logic [R2-1:0] c3_norm[QW+1];
  logic [R2-1:0] c3_rx  [QW+1];
  logic [R2-1:0] c3_ry  [QW+1];
  logic [QW-1:0] c3_qx  [QW+1];
  logic [QW-1:0] c3_qy  [QW+1];
  logic [P3W-1:0] c3_pay[QW+1];

  assign c3_v[0]    = ve_r;
  assign c3_norm[0] = norm_e_r;
  assign c3_rx[0]   = rx_e_r;
  assign c3_ry[0]   = ry_e_r;
  assign c3_qx[0]   = '0;
  assign c3_qy[0]   = '0;
  assign c3_pay[0]  = p3_r;

  for (genvar i = 0; i < QW; i++) begin : g_div
    h2e_div_cell #(.NW(R2), .PW(P3W)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(c3_v[i]), .in_norm(c3_norm[i]),
      .in_rem_x(c3_rx[i]), .in_rem_y(c3_ry[i]),
      .in_q_x(c3_qx[i]), .in_q_y(c3_qy[i]), .in_pay(c3_pay[i]),
      .out_valid(c3_v[i+1]), .out_norm(c3_norm[i+1]),
      .out_rem_x(c3_rx[i+1]), .out_rem_y(c3_ry[i+1]),
      .out_q_x(c3_qx[i+1]), .out_q_y(c3_qy[i+1]), .out_pay(c3_pay[i+1])
    );
  end

  // Stage F: signs, ordering and eigenvalue saturation.
  logic signed [EW-1:0] e1_f, e0_f, es_f, el_f;
  logic neg_x, neg_y, nz, big_x, big_y;
  logic [QW-1:0] clip_x, clip_y, mag_x, mag_y;
  logic [EW-1:0] abs0, abs1;
  logic signed [h2e_pkg::VEC_W-1:0] lx, ly, sx, sy, vsx, vsy, vlx, vly;
  logic signed [CW-1:0] es_w, el_w;
  logic [h2e_pkg::EIG_W-1:0] es_sat, el_sat;
  logic [h2e_pkg::OUT_TDATA_W-1:0] out_nxt;
  logic out_valid_r;
  logic [h2e_pkg::OUT_TDATA_W-1:0] out_data_r;

  always_comb begin
    e1_f   = c3_pay[QW][EW-1:0];
    e0_f   = c3_pay[QW][2*EW-1:EW];
    neg_x  = c3_pay[QW][2*EW];
    neg_y  = c3_pay[QW][2*EW+1];
    nz     = c3_pay[QW][2*EW+2];
    big_x  = c3_pay[QW][2*EW+3];
    big_y  = c3_pay[QW][2*EW+4];
    clip_x = c3_pay[QW][2*EW+5+QW-1:2*EW+5];
    clip_y = c3_pay[QW][P3W-1:2*EW+5+QW];

    mag_x = nz ? (big_x ? {QW{1'b1}} : c3_qx[QW]) : clip_x;
    mag_y = nz ? (big_y ? {QW{1'b1}} : c3_qy[QW]) : clip_y;
    lx    = neg_x ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
    ly    = neg_y ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
    sx    = -ly;
    sy    = lx;

    abs0 = e0_f[EW-1] ? EW'(-e0_f) : EW'(e0_f);
    abs1 = e1_f[EW-1] ? EW'(-e1_f) : EW'(e1_f);
    if (abs0 > abs1) begin
      es_f = e1_f; el_f = e0_f;
      vsx = lx; vsy = ly; vlx = sx; vly = sy;
    end else begin
      es_f = e0_f; el_f = e1_f;
      vsx = sx; vsy = sy; vlx = lx; vly = ly;
    end

    es_w = CW'(es_f);
    el_w = CW'(el_f);
    if (es_w > h2e_pkg::EIG_MAX) es_sat = h2e_pkg::EIG_MAX[h2e_pkg::EIG_W-1:0];
    else if (es_w < h2e_pkg::EIG_MIN) es_sat = h2e_pkg::EIG_MIN[h2e_pkg::EIG_W-1:0];
    else es_sat = es_w[h2e_pkg::EIG_W-1:0];
    if (el_w > h2e_pkg::EIG_MAX) el_sat = h2e_pkg::EIG_MAX[h2e_pkg::EIG_W-1:0];
    else if (el_w < h2e_pkg::EIG_MIN) el_sat = h2e_pkg::EIG_MIN[h2e_pkg::EIG_W-1:0];
    else el_sat = el_w[h2e_pkg::EIG_W-1:0];

    out_nxt = {{OPAD{1'b0}}, vly, vlx, vsy, vsx, el_sat, es_sat};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= c3_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The eigenvalue of smaller magnitude always comes first.
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (($signed(out_tdata[18:0]) < 0
                     ? -$signed({out_tdata[18], out_tdata[18:0]})
                     : $signed({out_tdata[18], out_tdata[18:0]})) <=
                    ($signed(out_tdata[37:19]) < 0
                     ? -$signed({out_tdata[37], out_tdata[37:19]})
                     : $signed({out_tdata[37], out_tdata[37:19]}))))
    else $error("eigenvalues out of order");

  // Vector components are saturated symmetrically and never reach -32768.
  a_vec_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[53:38] != 16'h8000 && out_tdata[69:54] != 16'h8000 &&
                    out_tdata[85:70] != 16'h8000 && out_tdata[101:86] != 16'h8000))
    else $error("vector component outside saturation range");

  // The input side stalls only behind a result the receiver has not taken.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without a pending result");

  // The two eigenvectors are perpendicular: the small one is the large one rotated.
  a_perp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[53:38] == -out_tdata[101:86] ||
                    out_tdata[85:70] == -out_tdata[69:54]))
    else $error("eigenvectors not perpendicular");

endmodule

[tb/sv/tb_hessian2_eigen_decomposition_top.sv]
module tb_hessian2_eigen_decomposition_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EIG_W = h2e_pkg::EIG_W;
  localparam int VEC_W = h2e_pkg::VEC_W;
  localparam int EW = 16;
  localparam int IN_W = ((3 * EW + 7) / 8) * 8;
  localparam int PIPE_LAT = 2 * EW + 24;
  localparam int VEC_SAT = 32767;
  localparam int NORM_FLOOR_MAX = 65535;

  typedef struct packed {
    logic signed [VEC_W-1:0] large_y;
    logic signed [VEC_W-1:0] large_x;
    logic signed [VEC_W-1:0] small_y;
    logic signed [VEC_W-1:0] small_x;
    logic signed [EIG_W-1:0] eig_large;
    logic signed [EIG_W-1:0] eig_small;
  } eigen_t;

  typedef struct {
    logic signed [15:0] dxx;
    logic signed [15:0] dxy;
    logic signed [15:0] dyy;
    logic               has_typed;
    eigen_t             typed;
  } hess_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [h2e_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  logic [15:0] norm_floor_q = '0;
  eigen_t eigen_q[$];
  int n_fail = 0;
  int n_checked = 0;
  int n_sent = 0;
  int n_swapped = 0;
  int n_raw = 0;
  bit hold_req = 1'b0;
  bit burst_mode = 1'b0;

  hessian2_eigen_decomposition_top #(.ENTRY_WIDTH(EW)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("hessian2_eigen_decomposition_top test failed");
    $finish;
  end

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned c;
    r = 0;
    for (int k = 31; k >= 0; k--) begin
      c = r | (64'd1 << k);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Closed-form eigen pair; the perpendicular vector is formed after scaling.
  function automatic eigen_t solve_hessian(longint dxx, longint dxy, longint dyy,
                                           longint unsigned nfloor, output bit swapped,
                                           output bit raw);
    longint a, b, s, disc, vx, vy, lx, ly, sx, sy, e0, e1, t;
    longint unsigned norm;
    eigen_t r;
    a = dxx - dyy;
    b = 2 * dxy;
    s = dxx + dyy;
    disc = longint'(isqrt(longint'(a * a) + longint'(b * b)));
    vx = a + disc;
    vy = b;
    norm = isqrt(vx * vx + vy * vy);
    raw = !(norm > nfloor);
    lx = raw ? vx : (vx * 32768) / longint'(norm);
    ly = raw ? vy : (vy * 32768) / longint'(norm);
    lx = clip(lx, -VEC_SAT, VEC_SAT);
    ly = clip(ly, -VEC_SAT, VEC_SAT);
    sx = -ly;
    sy = lx;
    e0 = s - disc;
    e1 = s + disc;
    swapped = abs64(e0) > abs64(e1);
    if (swapped) begin
      t = e0; e0 = e1; e1 = t;
      t = sx; sx = lx; lx = t;
      t = sy; sy = ly; ly = t;
    end
    r.eig_small = EIG_W'(clip(e0, -262144, 262143));
    r.eig_large = EIG_W'(clip(e1, -262144, 262143));
    r.small_x = VEC_W'(sx);
    r.small_y = VEC_W'(sy);
    r.large_x = VEC_W'(lx);
    r.large_y = VEC_W'(ly);
    return r;
  endfunction

  task automatic send_hessian(logic signed [15:0] dxx, logic signed [15:0] dxy,
                              logic signed [15:0] dyy, bit has_typed, eigen_t typed);
    eigen_t e;
    bit sw, rw;
    e = solve_hessian(dxx, dxy, dyy, norm_floor_q, sw, rw);
    if (has_typed && typed != e) begin
      $error("directed row mismatch for dxx=%0d dxy=%0d dyy=%0d", dxx, dxy, dyy);
      n_fail++;
    end
    eigen_q.push_back(e);
    n_swapped += sw;
    n_raw += rw;
    in_tdata <= {dyy, dxy, dxx};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    n_sent++;
    @(negedge clk);
    if (!burst_mode && $urandom_range(99) < 24) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic drain_pipe();
    in_tvalid <= 1'b0;
    while (eigen_q.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 4) @(negedge clk);
  endtask

  task automatic write_norm_floor(logic [15:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    norm_floor_q = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random(int n);
    logic signed [15:0] x, y, z;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(4))
        0: begin
          x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
        end
        1: begin
          x = 16'(int'($urandom_range(0, 40)) - 20);
          y = 16'(int'($urandom_range(0, 40)) - 20);
          z = 16'(int'($urandom_range(0, 40)) - 20);
        end
        2: begin
          // Diagonal matrices reach the zero-vector case when dxx <= dyy.
          x = 16'($urandom); y = '0; z = 16'($urandom);
        end
        3: begin
          x = 16'($urandom); y = 16'(int'($urandom_range(0, 6)) - 3); z = x;
        end
        default: begin
          x = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
          y = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
          z = 16'($urandom);
        end
      endcase
      send_hessian(x, y, z, 1'b0, '0);
    end
  endtask

  // Receiver: random stalls, a quiet stretch, and one long hold on request.
  initial begin
    int hold_cycles;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        hold_cycles = 0;
        while (hold_cycles < 3 * PIPE_LAT) begin
          @(negedge clk);
          hold_cycles++;
        end
        hold_req = 1'b0;
        out_tready <= 1'b1;
      end else begin
        out_tready <= burst_mode || ($urandom_range(99) >= 24);
      end
    end
  end

  always @(posedge clk) begin
    eigen_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[2*EIG_W+4*VEC_W-1:0];
      if (eigen_q.size() == 0) begin
        $error("result transaction with nothing expected");
        n_fail++;
      end else begin
        want = eigen_q.pop_front();
        n_checked++;
        if (got.eig_small !== want.eig_small) begin
          $error("eig_small_x2 expected %0d got %0d", want.eig_small, got.eig_small);
          n_fail++;
        end
        if (got.eig_large !== want.eig_large) begin
          $error("eig_large_x2 expected %0d got %0d", want.eig_large, got.eig_large);
          n_fail++;
        end
        if (got.small_x !== want.small_x) begin
          $error("vec_small_x expected %0d got %0d", want.small_x, got.small_x);
          n_fail++;
        end
        if (got.small_y !== want.small_y) begin
          $error("vec_small_y expected %0d got %0d", want.small_y, got.small_y);
          n_fail++;
        end
        if (got.large_x !== want.large_x) begin
          $error("vec_large_x expected %0d got %0d", want.large_x, got.large_x);
          n_fail++;
        end
        if (got.large_y !== want.large_y) begin
          $error("vec_large_y expected %0d got %0d", want.large_y, got.large_y);
          n_fail++;
        end
      end
    end
  end

  initial begin
    hess_row_t rows[$];
    // Typed result: the zero matrix gives zero eigenvalues and zero vectors.
    rows.push_back('{16'sd0, 16'sd0, 16'sd0, 1'b1, '0});
    rows.push_back('{16'sd5, 16'sd0, 16'sd3, 1'b0, '0});
    rows.push_back('{16'sd3, 16'sd0, 16'sd5, 1'b0, '0});
    rows.push_back('{16'sd0, 16'sd1, 16'sd0, 1'b0, '0});
    rows.push_back('{16'sd7, 16'sd0, 16'sd7, 1'b0, '0});
    rows.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, '0});
    rows.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '0});
    rows.push_back('{16'sh7fff, 16'sh8000, 16'sh8000, 1'b0, '0});
    rows.push_back('{16'sh8000, 16'sh7fff, 16'sh7fff, 1'b0, '0});
    rows.push_back('{16'sh7fff, 16'sd0, 16'sh8000, 1'b0, '0});
    rows.push_back('{16'sh8000, 16'sd0, 16'sh7fff, 1'b0, '0});
    rows.push_back('{-16'sd1, -16'sd1, -16'sd1, 1'b0, '0});
    rows.push_back('{16'sd1, -16'sd1, -16'sd1, 1'b0, '0});
    rows.push_back('{-16'sd100, 16'sd50, 16'sd100, 1'b0, '0});
    rows.push_back('{16'sh5555, 16'shaaaa, 16'sh5555, 1'b0, '0});
    rows.push_back('{16'shaaaa, 16'sh5555, 16'shaaaa, 1'b0, '0});
    rows.push_back('{16'sd0, 16'sh8000, 16'sd0, 1'b0, '0});
    rows.push_back('{16'sd2, 16'sd0, -16'sd2, 1'b0, '0});

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) send_hessian(rows[i].dxx, rows[i].dxy, rows[i].dyy,
                                   rows[i].has_typed, rows[i].typed);
    drain_pipe();

    foreach (rows[i]) begin
      if (i == 0) write_norm_floor(16'd0);
    end
    send_random(150);

    // Sender keeps offering while the receiver holds off.
    hold_req = 1'b1;
    burst_mode = 1'b1;
    send_random(3 * PIPE_LAT);
    burst_mode = 1'b0;
    drain_pipe();

    write_norm_floor(16'(NORM_FLOOR_MAX));
    foreach (rows[i]) send_hessian(rows[i].dxx, rows[i].dxy, rows[i].dyy, 1'b0, '0);
    send_random(100);
    drain_pipe();

    write_norm_floor(16'($urandom_range(1, 40)));
    send_random(100);
    drain_pipe();

    write_norm_floor(16'($urandom));
    send_random(80);
    drain_pipe();

    $display("Sent %0d Hessians over four norm_floor settings; checked %0d results.",
             n_sent, n_checked);
    $display("Swapped eigen order %0d times, unnormalized vectors %0d times.",
             n_swapped, n_raw);
    if (n_fail == 0 && eigen_q.size() == 0) begin
      $display("hessian2_eigen_decomposition_top test passed");
    end else begin
      $display("hessian2_eigen_decomposition_top test failed");
    end
    $finish;
  end

endmodule
